>>> design/distance_vector_route_table_macros.svh
// Assertion macros for the distance-vector route table.
// Used by design/distance_vector_route_table.sv; no other dependencies.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define DVRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DVRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DVRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DVRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/dvrt_pkg.sv
// Shared types and codes for the distance-vector route table.
// No dependencies; used by dvrt_cell and distance_vector_route_table.
`default_nettype none
package dvrt_pkg;
    typedef struct packed {
        logic [15:0] dest;
        logic [7:0]  cost;
        logic [15:0] hop;
    } t_entry;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic scan;
        logic compact;
        logic clear;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam logic [1:0] ACT_HELLO = 2'd0;
    localparam logic [1:0] ACT_ADV   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    // reserved action: changes nothing and reports ignored
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] OUT_ADD_NEW   = 3'd0;
    localparam logic [2:0] OUT_ADD_EQUAL = 3'd1;
    localparam logic [2:0] OUT_REPLACED  = 3'd2;
    localparam logic [2:0] OUT_REFRESHED = 3'd3;
    localparam logic [2:0] OUT_IGNORED   = 3'd4;
    localparam logic [2:0] OUT_FULL      = 3'd5;
    localparam logic [2:0] OUT_READ_OK   = 3'd6;
    localparam logic [2:0] OUT_READ_OOR  = 3'd7;

    localparam logic [7:0] COST_DIRECT = 8'd1;
    localparam logic [7:0] COST_MAX    = 8'd255;
    localparam logic [1:0] MAX_PATHS_RESET = 2'd3;
endpackage
`default_nettype wire

>>> design/dvrt_cell.sv
// One route table cell: holds an entry and its drop mark.
// Depends on dvrt_pkg.
`default_nettype none
module dvrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dvrt_pkg::t_cell_ctl i_ctl,
    input  wire dvrt_pkg::t_entry   i_up_entry,
    input  wire logic               i_up_mark,
    input  wire logic               i_dn_mark,
    input  wire logic               i_load,
    input  wire dvrt_pkg::t_entry   i_load_entry,
    output dvrt_pkg::t_entry        o_entry,
    output logic                    o_mark
);
    dvrt_pkg::t_entry r_entry;
    logic             r_mark;

    // drop mark: rides with the entry on scan, bubbles holes upward on compact
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else if (i_ctl.scan) begin
            r_mark <= i_up_mark;
        end else if (i_ctl.compact) begin
            r_mark <= r_mark ? i_up_mark : i_dn_mark;
        end else if (i_ctl.clear) begin
            r_mark <= 1'b0;
        end
    end

    // entry: shift from upper neighbor, fill a hole, or take an appended route
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_entry <= i_up_entry;
        end else if (i_ctl.compact && r_mark) begin
            r_entry <= i_up_entry;
        end else if (i_load) begin
            r_entry <= i_load_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_mark  = r_mark;
endmodule
`default_nettype wire

>>> design/distance_vector_route_table.sv
// Top level of the distance-vector route table: control, head unit, cell chain.
// Depends on dvrt_pkg, dvrt_cell and distance_vector_route_table_macros.svh.
//
// Every request rotates the whole table once through a ring of TABLE_DEPTH
// cells, with a head unit looking at one entry per cycle. When routes are
// removed, a compaction pass then moves holes to the top, one cell per
// cycle. A final state (ST_FIN) appends a route and registers the result,
// holding while an earlier result still waits to be taken. A new request is
// taken while the previous result still waits on the output.
`default_nettype none
`include "distance_vector_route_table_macros.svh"
module distance_vector_route_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_neighbor,
    input  wire logic [15:0] i_destination,
    input  wire logic [7:0]  i_advertised_cost,
    input  wire logic [5:0]  i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_outcome,
    output logic [1:0]       o_removed_count,
    output logic [6:0]       o_entry_total,
    output logic [15:0]      o_read_destination,
    output logic [7:0]       o_read_cost,
    output logic [15:0]      o_read_next_hop,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_max_paths
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    dvrt_pkg::t_state    r_state;
    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_count, r_kept;
    logic [1:0]          r_maxp;
    logic [1:0]          r_action;
    logic [15:0]         r_nb, r_dst;
    logic [7:0]          r_nc;
    logic [5:0]          r_ridx;
    logic                r_updated, r_found, r_better, r_same, r_hit;
    logic [1:0]          r_equal, r_removed;
    dvrt_pkg::t_entry    r_rd;
    logic                r_ov;
    logic [2:0]          r_o_outcome;
    logic [1:0]          r_o_removed;
    dvrt_pkg::t_entry    r_o_rd;

    logic                n_updated, n_found, n_better, n_same, n_hit, n_mark;
    logic [1:0]          n_equal, n_removed;
    dvrt_pkg::t_entry    n_rd, w_tail, w_head, w_app_entry;
    logic                w_live, w_last, w_fin_go, w_room, w_append;
    logic [2:0]          w_outcome;
    dvrt_pkg::t_cell_ctl w_ctl;
    dvrt_pkg::t_entry    w_ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_mark;

    assign o_in_ready  = (r_state == dvrt_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_head      = w_ent[0];
    assign w_live      = CW'(r_idx) < r_count;
    assign w_last      = (r_idx == IW'(TABLE_DEPTH - 1));
    assign w_fin_go    = (r_state == dvrt_pkg::ST_FIN) && (!r_ov || i_out_ready);
    assign w_room      = r_kept < CW'(TABLE_DEPTH);

    // head unit: judge the entry leaving cell 0 and send it back to the tail
    always_comb begin
        w_tail    = w_head;
        n_mark    = 1'b0;
        n_updated = r_updated;
        n_found   = r_found;
        n_better  = r_better;
        n_same    = r_same;
        n_equal   = r_equal;
        n_hit     = r_hit;
        n_rd      = r_rd;
        if (w_live) begin
            case (r_action)
                dvrt_pkg::ACT_HELLO: begin
                    if (w_head.dest == r_nb) begin
                        if (w_head.hop == r_nb) begin
                            w_tail.cost = dvrt_pkg::COST_DIRECT;
                            n_updated   = 1'b1;
                        end else if (w_head.cost > dvrt_pkg::COST_DIRECT) begin
                            n_mark = 1'b1;
                        end
                    end
                end
                dvrt_pkg::ACT_ADV: begin
                    if (w_head.dest == r_dst) begin
                        n_found = 1'b1;
                        if (r_nc < w_head.cost) begin
                            if (!r_better) begin
                                n_better = 1'b1;
                                w_tail   = '{dest: r_dst, cost: r_nc, hop: r_nb};
                            end else begin
                                n_mark = 1'b1;
                            end
                        end else if (r_nc == w_head.cost) begin
                            if (r_equal != 2'd3) n_equal = r_equal + 2'd1;
                            if (w_head.hop == r_nb) n_same = 1'b1;
                        end
                    end
                end
                dvrt_pkg::ACT_READ: begin
                    if (32'(r_idx) == 32'(r_ridx)) begin
                        n_hit = 1'b1;
                        n_rd  = w_head;
                    end
                end
                default: begin
                end
            endcase
        end
        n_removed = (n_mark && r_removed != 2'd3) ? r_removed + 2'd1 : r_removed;
    end

    // decide the result and any append at the end of the request
    always_comb begin
        w_outcome   = dvrt_pkg::OUT_IGNORED;
        w_append    = 1'b0;
        w_app_entry = '{dest: r_dst, cost: r_nc, hop: r_nb};
        case (r_action)
            dvrt_pkg::ACT_HELLO: begin
                w_app_entry = '{dest: r_nb, cost: dvrt_pkg::COST_DIRECT, hop: r_nb};
                if (r_updated) begin
                    w_outcome = dvrt_pkg::OUT_REFRESHED;
                end else begin
                    w_append  = w_room;
                    w_outcome = w_room ? dvrt_pkg::OUT_ADD_NEW : dvrt_pkg::OUT_FULL;
                end
            end
            dvrt_pkg::ACT_ADV: begin
                if (r_better) begin
                    w_outcome = dvrt_pkg::OUT_REPLACED;
                end else if (r_equal != 2'd0) begin
                    if (!r_same && r_equal < r_maxp) begin
                        w_append  = w_room;
                        w_outcome = w_room ? dvrt_pkg::OUT_ADD_EQUAL : dvrt_pkg::OUT_FULL;
                    end
                end else if (!r_found) begin
                    w_append  = w_room;
                    w_outcome = w_room ? dvrt_pkg::OUT_ADD_NEW : dvrt_pkg::OUT_FULL;
                end
            end
            dvrt_pkg::ACT_READ: begin
                w_outcome = r_hit ? dvrt_pkg::OUT_READ_OK : dvrt_pkg::OUT_READ_OOR;
            end
            default: begin
            end
        endcase
    end

    assign w_ctl.scan    = (r_state == dvrt_pkg::ST_SCAN);
    assign w_ctl.compact = (r_state == dvrt_pkg::ST_CMP);
    assign w_ctl.clear   = w_fin_go;

    // cell chain: each cell takes from its upper neighbor, the top from the head
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        dvrt_pkg::t_entry w_up_entry;
        logic             w_up_mark, w_dn_mark, w_load;
        if (gi == TABLE_DEPTH - 1) begin : g_top
            assign w_up_entry = w_tail;
            assign w_up_mark  = w_ctl.compact ? 1'b1 : n_mark;
        end else begin : g_mid
            assign w_up_entry = w_ent[gi+1];
            assign w_up_mark  = w_mark[gi+1];
        end
        if (gi == 0) begin : g_bot
            assign w_dn_mark = 1'b0;
        end else begin : g_upr
            assign w_dn_mark = w_mark[gi-1];
        end
        assign w_load = w_fin_go && w_append && (r_kept == CW'(gi));
        dvrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_up_entry   (w_up_entry),
            .i_up_mark    (w_up_mark),
            .i_dn_mark    (w_dn_mark),
            .i_load       (w_load),
            .i_load_entry (w_app_entry),
            .o_entry      (w_ent[gi]),
            .o_mark       (w_mark[gi])
        );
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvrt_pkg::ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_maxp  <= dvrt_pkg::MAX_PATHS_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_maxp <= i_cfg_max_paths;
            // raise the result flag on completion, drop it when taken
            if (w_fin_go) begin
                r_ov <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                dvrt_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= dvrt_pkg::ST_SCAN;
                    end
                end
                dvrt_pkg::ST_SCAN: begin
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) begin
                        r_state <= (n_removed != 2'd0) ? dvrt_pkg::ST_CMP
                                                       : dvrt_pkg::ST_FIN;
                    end
                end
                dvrt_pkg::ST_CMP: begin
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) r_state <= dvrt_pkg::ST_FIN;
                end
                dvrt_pkg::ST_FIN: begin
                    if (w_fin_go) begin
                        r_count <= r_kept + CW'(w_append);
                        r_state <= dvrt_pkg::ST_IDLE;
                    end
                end
                default: r_state <= dvrt_pkg::ST_IDLE;
            endcase
        end
    end

    // request fields, scan accumulators and result registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action  <= i_action;
            r_nb      <= i_neighbor;
            r_dst     <= i_destination;
            r_nc      <= (i_advertised_cost == dvrt_pkg::COST_MAX) ? dvrt_pkg::COST_MAX
                                                                  : i_advertised_cost + 8'd1;
            r_ridx    <= i_read_index;
            r_updated <= 1'b0;
            r_found   <= 1'b0;
            r_better  <= 1'b0;
            r_same    <= 1'b0;
            r_hit     <= 1'b0;
            r_equal   <= 2'd0;
            r_removed <= 2'd0;
            r_kept    <= '0;
            r_rd      <= '0;
        end else if (r_state == dvrt_pkg::ST_SCAN) begin
            r_updated <= n_updated;
            r_found   <= n_found;
            r_better  <= n_better;
            r_same    <= n_same;
            r_hit     <= n_hit;
            r_equal   <= n_equal;
            r_removed <= n_removed;
            r_rd      <= n_rd;
            if (w_live && !n_mark) r_kept <= r_kept + 1'b1;
        end
        if (w_fin_go) begin
            r_o_outcome <= w_outcome;
            r_o_removed <= r_removed;
            r_o_rd      <= r_hit ? r_rd : '0;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_outcome          = r_o_outcome;
    assign o_removed_count    = r_o_removed;
    assign o_entry_total      = 7'(r_count);
    assign o_read_destination = r_o_rd.dest;
    assign o_read_cost        = r_o_rd.cost;
    assign o_read_next_hop    = r_o_rd.hop;

    `DVRT_ASSERT_NOW(a_idle_marks_clear, i_clk, i_rst_n, r_state == dvrt_pkg::ST_IDLE, w_mark == '0)
    `DVRT_ASSERT_NOW(a_compact_has_drop, i_clk, i_rst_n, r_state == dvrt_pkg::ST_CMP, r_removed != 2'd0)
    `DVRT_ASSERT_NEXT(a_fin_gives_result, i_clk, i_rst_n, w_fin_go, o_out_valid)
    `DVRT_ASSERT_NEXT(a_scan_starts_zero, i_clk, i_rst_n, o_in_ready && i_in_valid, r_idx == '0)
    `DVRT_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
endmodule
`default_nettype wire
